// ===== rtl/srs3_pkg.sv =====
// ----------------------------------------------------------------------------
// srs3_pkg
// Types, codes and helpers shared by the S3 record character decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srs3_pkg;

   // parse phase of the current line
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_TYPE  = 3'd1,
      PH_COUNT = 3'd2,
      PH_ADDR  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5,
      PH_SKIP  = 3'd6,
      PH_SPARE = 3'd7
   } phase_type;

   // result codes
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_CSERR  = 2'd2,
      KIND_HEXERR = 2'd3
   } kind_type;

   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [3:0] TYPE_NONE  = 4'hF;
   localparam logic [3:0] ADDR_CHARS = 4'd8;
   localparam logic [7:0] COUNT_OVH  = 8'd5;

   // decoder state
   typedef struct packed {
      phase_type  phase;
      logic [3:0] record_type;
      logic [7:0] count_value;
      logic [3:0] field_char_index;
      logic [7:0] data_left;
      logic [3:0] high_nibble;
      logic [7:0] sum_acc;
      logic       halted;
   } state_type;

   // one result beat from the step logic
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
   } result_type;

   // decoded hex digit
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         // letters A-F / a-f: low three bits 1..6 map to 10..15
         h.value = {1'b0, c[2:0]} + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srs3_if.sv =====
// ----------------------------------------------------------------------------
// srs3 channel interfaces
// Valid/ready channels for text characters in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface srs3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;

   modport source (output valid, output text_char, input ready);
   modport sink   (input valid, input text_char, output ready);
endinterface

interface srs3_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/srs3_char_step.sv =====
// ----------------------------------------------------------------------------
// srs3_char_step
// Next-state and result logic for one text character.
// ----------------------------------------------------------------------------
`default_nettype none

module srs3_char_step (
   input  srs3_pkg::state_type  state_cur,
   input  logic [7:0]           text_char,
   output srs3_pkg::state_type  state_nxt,
   output srs3_pkg::result_type result
);

   srs3_pkg::hex_type hex;
   logic [7:0]        byte_val;
   logic [3:0]        idx_inc;

   assign hex      = srs3_pkg::hex_decode(text_char);
   assign byte_val = {state_cur.high_nibble, hex.value};
   assign idx_inc  = state_cur.field_char_index + 4'd1;

   always_comb begin
      state_nxt = state_cur;
      result    = '{valid: 1'b0, kind: srs3_pkg::KIND_DATA, data_byte: 8'd0};

      if (!state_cur.halted) begin
         case (state_cur.phase)
            // line must start with S
            srs3_pkg::PH_START: begin
               if (text_char == srs3_pkg::CHAR_S) begin
                  state_nxt.phase = srs3_pkg::PH_TYPE;
               end else if (text_char != srs3_pkg::CHAR_LF) begin
                  state_nxt.phase = srs3_pkg::PH_SKIP;
               end
            end

            // record type digit
            srs3_pkg::PH_TYPE: begin
               if (text_char == srs3_pkg::CHAR_LF) begin
                  state_nxt.phase = srs3_pkg::PH_START;
               end else begin
                  if (text_char >= srs3_pkg::CHAR_ZERO && text_char <= srs3_pkg::CHAR_NINE) begin
                     state_nxt.record_type = text_char[3:0];
                  end else begin
                     state_nxt.record_type = srs3_pkg::TYPE_NONE;
                  end
                  if (text_char == srs3_pkg::CHAR_THREE) begin
                     state_nxt.phase            = srs3_pkg::PH_COUNT;
                     state_nxt.field_char_index = 4'd0;
                     state_nxt.sum_acc          = 8'd0;
                     state_nxt.count_value      = 8'd0;
                     state_nxt.data_left        = 8'd0;
                     state_nxt.high_nibble      = 4'd0;
                  end else begin
                     state_nxt.phase = srs3_pkg::PH_SKIP;
                  end
               end
            end

            // hex fields of an S3 line
            srs3_pkg::PH_COUNT, srs3_pkg::PH_ADDR,
            srs3_pkg::PH_DATA, srs3_pkg::PH_CHECK: begin
               if (!hex.ok) begin
                  state_nxt.halted = 1'b1;
                  result.valid     = 1'b1;
                  result.kind      = srs3_pkg::KIND_HEXERR;
               end else if (!state_cur.field_char_index[0]) begin
                  // first digit of a byte
                  state_nxt.high_nibble      = hex.value;
                  state_nxt.field_char_index = idx_inc;
               end else begin
                  state_nxt.field_char_index = idx_inc;
                  case (state_cur.phase)
                     srs3_pkg::PH_COUNT: begin
                        state_nxt.count_value      = byte_val;
                        state_nxt.sum_acc          = state_cur.sum_acc + byte_val;
                        state_nxt.data_left        = (byte_val > srs3_pkg::COUNT_OVH) ?
                                                     byte_val - srs3_pkg::COUNT_OVH : 8'd0;
                        state_nxt.field_char_index = 4'd0;
                        state_nxt.phase            = srs3_pkg::PH_ADDR;
                     end
                     srs3_pkg::PH_ADDR: begin
                        state_nxt.sum_acc = state_cur.sum_acc + byte_val;
                        if (idx_inc >= srs3_pkg::ADDR_CHARS) begin
                           state_nxt.field_char_index = 4'd0;
                           state_nxt.phase = (state_cur.data_left != 8'd0) ?
                                             srs3_pkg::PH_DATA : srs3_pkg::PH_CHECK;
                        end
                     end
                     srs3_pkg::PH_DATA: begin
                        state_nxt.sum_acc          = state_cur.sum_acc + byte_val;
                        state_nxt.field_char_index = 4'd0;
                        state_nxt.data_left        = state_cur.data_left - 8'd1;
                        if (state_cur.data_left == 8'd1) begin
                           state_nxt.phase = srs3_pkg::PH_CHECK;
                        end
                        result.valid     = 1'b1;
                        result.kind      = srs3_pkg::KIND_DATA;
                        result.data_byte = byte_val;
                     end
                     default: begin
                        // checksum byte
                        state_nxt.field_char_index = 4'd0;
                        result.valid = 1'b1;
                        if (~state_cur.sum_acc == byte_val) begin
                           state_nxt.phase = srs3_pkg::PH_SKIP;
                           result.kind     = srs3_pkg::KIND_COMMIT;
                        end else begin
                           state_nxt.halted = 1'b1;
                           result.kind      = srs3_pkg::KIND_CSERR;
                        end
                     end
                  endcase
               end
            end

            // skip to newline
            default: begin
               if (text_char == srs3_pkg::CHAR_LF) begin
                  state_nxt.phase = srs3_pkg::PH_START;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/srecord_s3_char_decoder_core.sv =====
// A character goes from the input register through the step logic to the
// result register. Throughput: one character per cycle while the result
// register has room; the state update is a single pass of the step logic.
// Reset (synchronous, active high) returns the parser to line start, clears
// the halt flag and empties both register stages.
// ----------------------------------------------------------------------------
// srecord_s3_char_decoder_core
// S3 record text decoder: emits data bytes, commit and error results.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_s3_char_decoder_core (
   input  wire             clock,
   input  wire             reset,
   srs3_req_if.sink        req_bus,
   srs3_rsp_if.source      rsp_bus
);

   logic [7:0]           char_ff;
   logic                 char_vld_ff;
   srs3_pkg::state_type  state_ff;
   srs3_pkg::state_type  state_in;
   srs3_pkg::result_type step_res;
   logic                 rsp_valid_ff;
   srs3_pkg::kind_type   rsp_kind_ff;
   logic [7:0]           rsp_data_ff;
   logic                 advance;
   logic                 out_free;

   srs3_char_step u_step (
      .state_cur (state_ff),
      .text_char (char_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   // input beat moves on when its result (if any) has room
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = char_vld_ff && (out_free || !step_res.valid);
   assign req_bus.ready = !char_vld_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         char_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         char_vld_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         char_ff <= req_bus.text_char;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: srs3_pkg::PH_START, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && step_res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && step_res.valid) begin
         rsp_kind_ff <= step_res.kind;
         rsp_data_ff <= step_res.data_byte;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.kind      = rsp_kind_ff;
   assign rsp_bus.data_byte = rsp_data_ff;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the S3 record character decoder. It streams S-record
// text through the request channel: S3 records with random counts, addresses
// and data, skipped lines and noise. A scoreboard tracks the parse state one
// character at a time and matches every result beat in order. One record at
// the end halts the block through a checksum or hex digit fault.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam int         SEND_TOTAL = 1050;
   localparam int         CALM_FROM  = 850;
   localparam int         HOLD_AT    = 200;
   localparam int         HOLD_LEN   = 150;

   // defects injected into an S3 record
   typedef enum {CLEAN, BAD_SUM, BAD_DIGIT} flaw_type;
   // lines the decoder skips
   typedef enum {LINE_TEXT, LINE_OTHER_TYPE, LINE_BARE_S, LINE_EMPTY} line_form_type;

   typedef struct packed {
      srs3_pkg::kind_type kind;
      logic [7:0]         data_byte;
   } decoded_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srs3_req_if req_bus ();
   srs3_rsp_if rsp_bus ();

   srecord_s3_char_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= srs3_pkg::CHAR_ZERO && c <= srs3_pkg::CHAR_NINE) begin
         t = c - srs3_pkg::CHAR_ZERO;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
      end else begin
         return 5'h00;
      end
      return {1'b1, t[3:0]};
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: follows the line parser and holds the results still due
   // ------------------------------------------------------------------------
   class s3_tracker_type;
      decoded_beat_type    due_results[$];
      srs3_pkg::phase_type parse_phase  = srs3_pkg::PH_START;
      logic [3:0]          rec_type     = 4'd0;
      logic [7:0]          rec_len      = 8'd0;
      logic [3:0]          digit_pos    = 4'd0;
      logic [7:0]          bytes_left   = 8'd0;
      logic [3:0]          first_nibble = 4'd0;
      logic [7:0]          running_sum  = 8'd0;
      bit                  stopped      = 1'b0;
      int errors;
      int data_beats;
      int commits;
      int halts;

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
      endfunction

      function void owe(srs3_pkg::kind_type k, logic [7:0] b);
         decoded_beat_type r;
         r.kind      = k;
         r.data_byte = b;
         due_results.push_back(r);
      endfunction

      // one accepted character beat
      function void note_char(logic [7:0] c);
         logic [4:0] digit;
         logic [7:0] value;
         if (stopped) return;

         case (parse_phase)
            srs3_pkg::PH_START: begin
               if (c == srs3_pkg::CHAR_S) parse_phase = srs3_pkg::PH_TYPE;
               else if (c != srs3_pkg::CHAR_LF) parse_phase = srs3_pkg::PH_SKIP;
               return;
            end
            srs3_pkg::PH_TYPE: begin
               if (c == srs3_pkg::CHAR_LF) begin
                  parse_phase = srs3_pkg::PH_START;
                  return;
               end
               rec_type = (c >= srs3_pkg::CHAR_ZERO && c <= srs3_pkg::CHAR_NINE) ?
                          c[3:0] : srs3_pkg::TYPE_NONE;
               if (c == srs3_pkg::CHAR_THREE) begin
                  parse_phase  = srs3_pkg::PH_COUNT;
                  digit_pos    = 4'd0;
                  running_sum  = 8'd0;
                  rec_len      = 8'd0;
                  bytes_left   = 8'd0;
                  first_nibble = 4'd0;
               end else begin
                  parse_phase = srs3_pkg::PH_SKIP;
               end
               return;
            end
            srs3_pkg::PH_COUNT, srs3_pkg::PH_ADDR,
            srs3_pkg::PH_DATA, srs3_pkg::PH_CHECK: ;
            default: begin
               // skipping to end of line (spare code acts the same)
               if (c == srs3_pkg::CHAR_LF) parse_phase = srs3_pkg::PH_START;
               return;
            end
         endcase

         // hex fields
         digit = hex_digit(c);
         if (!digit[4]) begin
            stopped = 1'b1;
            owe(srs3_pkg::KIND_HEXERR, 8'h00);
            return;
         end
         if (!digit_pos[0]) begin
            first_nibble = digit[3:0];
            digit_pos    = digit_pos + 4'd1;
            return;
         end
         value     = {first_nibble, digit[3:0]};
         digit_pos = digit_pos + 4'd1;

         case (parse_phase)
            srs3_pkg::PH_COUNT: begin
               rec_len     = value;
               running_sum = running_sum + value;
               bytes_left  = (value > srs3_pkg::COUNT_OVH) ?
                             value - srs3_pkg::COUNT_OVH : 8'd0;
               digit_pos   = 4'd0;
               parse_phase = srs3_pkg::PH_ADDR;
            end
            srs3_pkg::PH_ADDR: begin
               running_sum = running_sum + value;
               if (digit_pos >= srs3_pkg::ADDR_CHARS) begin
                  digit_pos   = 4'd0;
                  parse_phase = (bytes_left != 8'd0) ? srs3_pkg::PH_DATA : srs3_pkg::PH_CHECK;
               end
            end
            srs3_pkg::PH_DATA: begin
               running_sum = running_sum + value;
               digit_pos   = 4'd0;
               bytes_left  = bytes_left - 8'd1;
               if (bytes_left == 8'd0) parse_phase = srs3_pkg::PH_CHECK;
               owe(srs3_pkg::KIND_DATA, value);
            end
            default: begin
               digit_pos = 4'd0;
               if ((8'hFF ^ running_sum) == value) begin
                  parse_phase = srs3_pkg::PH_SKIP;
                  owe(srs3_pkg::KIND_COMMIT, 8'h00);
               end else begin
                  stopped = 1'b1;
                  owe(srs3_pkg::KIND_CSERR, 8'h00);
               end
            end
         endcase
      endfunction

      // one accepted result beat
      function void check_result(srs3_pkg::kind_type k, logic [7:0] b);
         decoded_beat_type want;
         if (due_results.size() == 0) begin
            flag($sformatf("unexpected result kind=%0d byte=%02h", k, b));
            return;
         end
         want = due_results.pop_front();
         if (k !== want.kind)
            flag($sformatf("kind: expected %0d, got %0d", want.kind, k));
         if (b !== want.data_byte)
            flag($sformatf("data_byte: expected %02h, got %02h", want.data_byte, b));
         case (k)
            srs3_pkg::KIND_DATA:   data_beats++;
            srs3_pkg::KIND_COMMIT: commits++;
            default:               halts++;
         endcase
      endfunction
   endclass

   s3_tracker_type tracker = new();
   logic [7:0]     line_buf[$];
   int             sent_count = 0;
   bit             calm = 1'b0;
   bit             hold_done = 1'b0;

   // ------------------------------------------------------------------------
   // Monitors: both channels sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) tracker.note_char(req_bus.text_char);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(srs3_pkg::kind_type'(rsp_bus.kind), rsp_bus.data_byte);
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stall bursts plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!hold_done && sent_count >= HOLD_AT) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            rsp_bus.ready <= 1'b1;
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(15) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c);
      if (!calm && $urandom_range(7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.text_char <= c;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sent_count++;
   endtask

   task automatic send_line();
      foreach (line_buf[k]) send_char(line_buf[k]);
   endtask

   task automatic send_text(input string s);
      line_buf = {};
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      send_line();
   endtask

   // two hex digits, letter case picked per digit
   function automatic void put_hex(input logic [7:0] b);
      logic [3:0] n;
      for (int i = 1; i >= 0; i--) begin
         n = b[i*4 +: 4];
         if (n < 4'd10) line_buf.push_back(srs3_pkg::CHAR_ZERO + n);
         else line_buf.push_back(($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10);
      end
   endfunction

   // random characters other than newline
   function automatic void put_junk(input int n);
      logic [7:0] c;
      repeat (n) begin
         do c = 8'($urandom); while (c == srs3_pkg::CHAR_LF);
         line_buf.push_back(c);
      end
   endfunction

   task automatic send_s3_record(input logic [7:0] count, input flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] bad;
      logic [4:0] probe;
      int         nbytes;
      int         pos;
      line_buf = {};
      line_buf.push_back(srs3_pkg::CHAR_S);
      line_buf.push_back(srs3_pkg::CHAR_THREE);
      put_hex(count);
      sum    = count;
      nbytes = 4 + ((count > srs3_pkg::COUNT_OVH) ? int'(count - srs3_pkg::COUNT_OVH) : 0);
      // address then data
      repeat (nbytes) begin
         b   = 8'($urandom);
         sum = sum + b;
         put_hex(b);
      end
      b = 8'hFF ^ sum;
      if (flaw == BAD_SUM) b = b ^ (8'h01 << $urandom_range(7));
      put_hex(b);
      if (flaw == BAD_DIGIT) begin
         // break one digit anywhere from the count to the checksum
         pos = $urandom_range(line_buf.size() - 1, 2);
         case ($urandom_range(3))
            0: bad = srs3_pkg::CHAR_LF;
            1: bad = CHAR_CR;
            default: begin
               do begin
                  bad   = 8'($urandom);
                  probe = hex_digit(bad);
               end while (probe[4]);
            end
         endcase
         line_buf[pos] = bad;
      end else if (flaw == CLEAN) begin
         if ($urandom_range(3) == 0) put_junk($urandom_range(6, 1));
         if ($urandom_range(2) == 0) line_buf.push_back(CHAR_CR);
      end
      line_buf.push_back(srs3_pkg::CHAR_LF);
      send_line();
   endtask

   task automatic send_other_line(input line_form_type form);
      logic [7:0] c;
      line_buf = {};
      case (form)
         LINE_TEXT: begin
            do c = 8'($urandom); while (c == srs3_pkg::CHAR_S || c == srs3_pkg::CHAR_LF);
            line_buf.push_back(c);
            put_junk($urandom_range(12));
         end
         LINE_OTHER_TYPE: begin
            line_buf.push_back(srs3_pkg::CHAR_S);
            do c = $urandom_range(1) ?
                   8'($urandom_range(srs3_pkg::CHAR_NINE, srs3_pkg::CHAR_ZERO)) :
                   8'($urandom);
            while (c == srs3_pkg::CHAR_THREE || c == srs3_pkg::CHAR_LF);
            line_buf.push_back(c);
            put_junk($urandom_range(12));
         end
         LINE_BARE_S: line_buf.push_back(srs3_pkg::CHAR_S);
         default: ;
      endcase
      line_buf.push_back(srs3_pkg::CHAR_LF);
      send_line();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int         rec_no;
      int         drain;
      logic [7:0] count;
      req_bus.valid     <= 1'b0;
      req_bus.text_char <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: blank line, bare S, other type, count zero record
      send_text("\n");
      send_text("S\n");
      send_text("S7\n");
      send_text("S300ffffFFFF03\n");

      // random records and skipped lines
      rec_no = 0;
      while (sent_count < SEND_TOTAL) begin
         if (sent_count >= CALM_FROM) calm = 1'b1;
         if ($urandom_range(99) < 65) begin
            rec_no++;
            if (rec_no == 4) begin
               count = 8'hFF;
            end else begin
               case ($urandom_range(9))
                  0, 1:    count = 8'($urandom_range(5));
                  8:       count = 8'($urandom_range(40, 17));
                  default: count = 8'($urandom_range(16, 6));
               endcase
            end
            send_s3_record(count, CLEAN);
         end else begin
            send_other_line(line_form_type'($urandom_range(3)));
         end
      end

      // halting record, then text that must be ignored
      calm = 1'b1;
      send_s3_record(8'($urandom_range(12)), $urandom_range(1) ? BAD_SUM : BAD_DIGIT);
      send_text("S30A0000000001020304050A\n");
      line_buf = {};
      put_junk(10);
      send_line();
      req_bus.valid <= 1'b0;

      // drain
      drain = 0;
      while (tracker.due_results.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (tracker.due_results.size() != 0)
         tracker.flag($sformatf("%0d results never arrived", tracker.due_results.size()));

      $display("Run: %0d characters, %0d records committed, %0d data bytes checked,",
               sent_count, tracker.commits, tracker.data_beats);
      $display("     %0d halt result(s), %0d mismatches.", tracker.halts, tracker.errors);
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/srs3_pkg.sv
rtl/srs3_if.sv
rtl/srs3_char_step.sv
rtl/srecord_s3_char_decoder_core.sv
test/testbench.sv
